// ----- src/avm_pkg.sv -----
// Shared types, constants and the segment decoder of the averaging voltmeter.
// Used by every module of the block; depends on nothing else.
package avm_pkg;

    // Field widths
    localparam int ADC_W  = 10;
    localparam int MV_W   = 14;
    localparam int SI_W   = 8;
    localparam int FS_W   = 14;
    localparam int SEG_W  = 8;
    localparam int DIG_W  = 4;

    // Averaging: a power-of-two sample count, so the divide is a shift
    localparam int AVG_LOG2 = 4;
    localparam int SAMPLES  = 1 << AVG_LOG2;
    localparam int CNT_W    = AVG_LOG2;
    localparam int SUM_W    = ADC_W + AVG_LOG2;

    // Display
    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 2;

    // Scaling: product of average and full scale, then divide by 1023
    localparam int PROD_W    = ADC_W + FS_W;
    localparam int DIV_SHIFT = 10;
    localparam int QUO_W     = PROD_W + 1 - DIV_SHIFT;
    localparam logic [PROD_W:0] ADC_FULL_CODE = (PROD_W + 1)'(1023);
    localparam logic [MV_W-1:0] MV_MAX        = 14'd9999;

    // Reciprocals for the decimal split (exact for values up to 9999)
    localparam int PRD_W = 2 * MV_W;
    localparam logic [PRD_W-1:0] RECIP_1000 = 28'd8389;
    localparam logic [PRD_W-1:0] RECIP_100  = 28'd10486;
    localparam logic [PRD_W-1:0] RECIP_10   = 28'd6554;

    // Configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE      = 2'd1;
    localparam logic [SI_W-1:0] SAMPLE_INTERVAL_RESET = 8'd13;
    localparam logic [FS_W-1:0] FULL_SCALE_RESET      = 14'd5000;

    typedef logic [DIG_W-1:0] digit_t;
    typedef digit_t [DIGIT_COUNT-1:0] digit_row_t;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             fresh;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [ADC_W-1:0] avg;
    } acc_item_t;

    typedef struct packed {
        tag_t            tag;
        logic [MV_W-1:0] mv;
    } scale_item_t;

    typedef struct packed {
        tag_t            tag;
        logic [MV_W-1:0] mv;
        digit_row_t      digits;
    } digit_item_t;

    // Active-low common-anode pattern, point off
    function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

// ----- src/avm_acc.sv -----
// Tick prescaler, sample accumulator and scan counter of the voltmeter.
// Depends on avm_pkg.
module avm_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [avm_pkg::ADC_W-1:0]     adc_sample,
    input  logic [avm_pkg::SI_W-1:0]      sample_interval,
    output logic                          out_valid,
    input  logic                          out_ready,
    output avm_pkg::acc_item_t            out_item
);

    logic [avm_pkg::SI_W-1:0]  tick_reg, tick_next;
    logic [avm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [avm_pkg::CNT_W-1:0] count_reg, count_next;
    logic [avm_pkg::POS_W-1:0] scan_reg, scan_next;
    logic                      valid_reg, valid_next;
    avm_pkg::acc_item_t        item_reg, item_next;

    logic                      take;
    logic [avm_pkg::SI_W-1:0]  tick_inc;
    logic [avm_pkg::SUM_W-1:0] sum_inc;
    logic                      sample_hit;
    logic                      avg_done;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Advance counters on each accepted tick
    always_comb
    begin
        take       = in_valid && in_ready;
        tick_inc   = tick_reg + 1'b1;
        sum_inc    = sum_reg + avm_pkg::SUM_W'(adc_sample);
        sample_hit = tick_inc >= sample_interval;
        avg_done   = sample_hit && (count_reg == avm_pkg::CNT_W'(avm_pkg::SAMPLES - 1));

        tick_next  = tick_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        item_next  = item_reg;
        valid_next = in_ready ? in_valid : valid_reg;

        if (take)
        begin
            scan_next = (scan_reg == avm_pkg::POS_W'(avm_pkg::DIGIT_COUNT - 1))
                        ? '0 : scan_reg + 1'b1;
            tick_next = sample_hit ? '0 : tick_inc;
            if (sample_hit)
            begin
                if (avg_done)
                begin
                    sum_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    sum_next   = sum_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            item_next.tag.pos   = scan_reg;
            item_next.tag.fresh = avg_done;
            item_next.avg       = sum_inc[avm_pkg::SUM_W-1:avm_pkg::AVG_LOG2];
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            scan_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg  <= tick_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ----- src/avm_scale.sv -----
// Millivolt scaling: average times full scale, divide by 1023, saturate.
// Three stages (multiply, quotient estimate, correct). Depends on avm_pkg.
module avm_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  avm_pkg::acc_item_t        in_item,
    input  logic [avm_pkg::FS_W-1:0]  full_scale_mv,
    output logic                      out_valid,
    input  logic                      out_ready,
    output avm_pkg::scale_item_t      out_item
);

    logic                         va_reg, vb_reg, vc_reg;
    logic                         rdy_a, rdy_b, rdy_c;
    avm_pkg::tag_t                tag_a_reg, tag_b_reg;
    logic [avm_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [avm_pkg::PROD_W-1:0]   x_reg;
    logic [avm_pkg::QUO_W-1:0]    est_reg, est_next;
    avm_pkg::scale_item_t         item_reg, item_next;

    logic [avm_pkg::PROD_W:0]     est_sum;
    logic [avm_pkg::PROD_W:0]     rem;
    logic [avm_pkg::QUO_W-1:0]    quo;

    assign rdy_c     = !vc_reg || out_ready;
    assign rdy_b     = !vb_reg || rdy_c;
    assign rdy_a     = !va_reg || rdy_b;
    assign in_ready  = rdy_a;
    assign out_valid = vc_reg;
    assign out_item  = item_reg;

    // Multiply, then estimate x/1023 as (x + x/1024 + x/2^20)/1024, then
    // correct the estimate by at most one with the remainder
    always_comb
    begin
        prod_next = avm_pkg::PROD_W'(in_item.avg) * avm_pkg::PROD_W'(full_scale_mv);

        est_sum  = {1'b0, prod_reg}
                 + (avm_pkg::PROD_W + 1)'(prod_reg >> avm_pkg::DIV_SHIFT)
                 + (avm_pkg::PROD_W + 1)'(prod_reg >> (2 * avm_pkg::DIV_SHIFT));
        est_next = est_sum[avm_pkg::PROD_W:avm_pkg::DIV_SHIFT];

        rem = {1'b0, x_reg} - {est_reg, {avm_pkg::DIV_SHIFT{1'b0}}}
            + (avm_pkg::PROD_W + 1)'(est_reg);
        quo = (rem >= avm_pkg::ADC_FULL_CODE) ? est_reg + 1'b1 : est_reg;

        item_next.tag = tag_b_reg;
        item_next.mv  = (quo > avm_pkg::QUO_W'(avm_pkg::MV_MAX))
                        ? avm_pkg::MV_MAX : quo[avm_pkg::MV_W-1:0];
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            prod_reg  <= prod_next;
            tag_a_reg <= in_item.tag;
        end
        if (rdy_b)
        begin
            est_reg   <= est_next;
            x_reg     <= prod_reg;
            tag_b_reg <= tag_a_reg;
        end
        if (rdy_c)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/avm_digits.sv -----
// Decimal split of a millivolt value (0..9999) into four digits, most
// significant first. Two stages: reciprocal multiplies, then remainders.
// Depends on avm_pkg.
module avm_digits (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  avm_pkg::scale_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output avm_pkg::digit_item_t  out_item
);

    logic                         vd_reg, ve_reg;
    logic                         rdy_d, rdy_e;
    avm_pkg::scale_item_t         src_reg;
    logic [3:0]                   q1000_reg, q1000_next;
    logic [6:0]                   q100_reg, q100_next;
    logic [9:0]                   q10_reg, q10_next;
    avm_pkg::digit_item_t         item_reg, item_next;

    logic [avm_pkg::PRD_W-1:0]    p1000, p100, p10;
    logic [6:0]                   r100;
    logic [9:0]                   r10;
    logic [avm_pkg::MV_W-1:0]     r1;

    assign rdy_e     = !ve_reg || out_ready;
    assign rdy_d     = !vd_reg || rdy_e;
    assign in_ready  = rdy_d;
    assign out_valid = ve_reg;
    assign out_item  = item_reg;

    // Quotients by 1000, 100 and 10 through reciprocal multiplies
    always_comb
    begin
        p1000      = avm_pkg::PRD_W'(in_item.mv) * avm_pkg::RECIP_1000;
        p100       = avm_pkg::PRD_W'(in_item.mv) * avm_pkg::RECIP_100;
        p10        = avm_pkg::PRD_W'(in_item.mv) * avm_pkg::RECIP_10;
        q1000_next = p1000[26:23];
        q100_next  = p100[26:20];
        q10_next   = p10[25:16];
    end

    // Digits as differences of neighboring quotients
    always_comb
    begin
        r100 = q100_reg - 7'(q1000_reg) * 7'd10;
        r10  = q10_reg - 10'(q100_reg) * 10'd10;
        r1   = src_reg.mv - avm_pkg::MV_W'(q10_reg) * avm_pkg::MV_W'(10);

        item_next.tag       = src_reg.tag;
        item_next.mv        = src_reg.mv;
        item_next.digits[0] = q1000_reg;
        item_next.digits[1] = r100[3:0];
        item_next.digits[2] = r10[3:0];
        item_next.digits[3] = r1[3:0];
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            if (rdy_d)
            begin
                vd_reg <= in_valid;
            end
            if (rdy_e)
            begin
                ve_reg <= vd_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy_d)
        begin
            src_reg   <= in_item;
            q1000_reg <= q1000_next;
            q100_reg  <= q100_next;
            q10_reg   <= q10_next;
        end
        if (rdy_e)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/avm_disp.sv -----
// Digit buffer, latest reading and the result register with the display
// outputs. Depends on avm_pkg.
module avm_disp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  avm_pkg::digit_item_t          in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [avm_pkg::SEG_W-1:0]     segment_pattern,
    output logic [avm_pkg::DIGIT_COUNT-1:0] digit_enable,
    output logic [avm_pkg::MV_W-1:0]      reading_mv,
    output logic                          new_reading
);

    avm_pkg::digit_row_t                  digit_reg;
    logic [avm_pkg::MV_W-1:0]             last_mv_reg;
    logic                                 valid_reg;
    logic [avm_pkg::SEG_W-1:0]            seg_reg, seg_next;
    logic [avm_pkg::DIGIT_COUNT-1:0]      en_reg, en_next;
    logic [avm_pkg::MV_W-1:0]             mv_reg, mv_next;
    logic                                 new_reg;
    logic                                 take;

    assign in_ready        = !valid_reg || out_ready;
    assign take            = in_valid && in_ready;
    assign out_valid       = valid_reg;
    assign segment_pattern = seg_reg;
    assign digit_enable    = en_reg;
    assign reading_mv      = mv_reg;
    assign new_reading     = new_reg;

    // Show the digit from the buffer as it stood before this transaction
    always_comb
    begin
        seg_next = avm_pkg::seg_code(digit_reg[in_item.tag.pos]);
        en_next  = ~(avm_pkg::DIGIT_COUNT'(1) << in_item.tag.pos);
        mv_next  = in_item.tag.fresh ? in_item.mv : last_mv_reg;
    end

    // Hold buffer, latest reading and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg   <= '0;
            last_mv_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (take && in_item.tag.fresh)
            begin
                digit_reg   <= in_item.digits;
                last_mv_reg <= in_item.mv;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seg_reg <= seg_next;
            en_reg  <= en_next;
            mv_reg  <= mv_next;
            new_reg <= in_item.tag.fresh;
        end
    end

endmodule

// ----- src/adc_average_voltmeter_display.sv -----
// Averaging voltmeter with a multiplexed four-digit display. Each input
// transaction is one timer tick carrying an ADC reading; each yields one
// result transaction with the segment pattern and digit enable for the
// scanned digit, the latest reading in millivolts and a flag for a fresh
// average. One transaction is taken per clock unless a stalled result holds
// the input; each tick passes seven register stages (accumulate,
// multiply, quotient estimate, quotient correction, reciprocal multiplies,
// digit split, result register), the first of which takes the tick itself.
// s_tready drops only when every stage is full and the result waits.
// Configuration writes are always taken. Depends on avm_pkg, avm_acc,
// avm_scale, avm_digits and avm_disp.
module adc_average_voltmeter_display (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [9:0] adc_sample
    // Results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] segment_pattern, [11:8] digit_enable, [25:12] reading_mv
    output logic [31:0]                       m_tdata,
    output logic                              m_tuser,   // [0] new_reading
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [avm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [avm_pkg::SI_W-1:0]   sample_interval_reg;
    logic [avm_pkg::FS_W-1:0]   full_scale_reg;

    logic                       acc_valid, acc_ready;
    avm_pkg::acc_item_t         acc_item;
    logic                       scl_valid, scl_ready;
    avm_pkg::scale_item_t       scl_item;
    logic                       dig_valid, dig_ready;
    avm_pkg::digit_item_t       dig_item;

    logic [avm_pkg::SEG_W-1:0]        segment_pattern;
    logic [avm_pkg::DIGIT_COUNT-1:0]  digit_enable;
    logic [avm_pkg::MV_W-1:0]         reading_mv;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= avm_pkg::SAMPLE_INTERVAL_RESET;
            full_scale_reg      <= avm_pkg::FULL_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                avm_pkg::CFG_SAMPLE_INTERVAL:
                    sample_interval_reg <= cfg_data[avm_pkg::SI_W-1:0];
                avm_pkg::CFG_FULL_SCALE:
                    full_scale_reg <= cfg_data[avm_pkg::FS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    avm_acc u_acc (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .adc_sample      (s_tdata[avm_pkg::ADC_W-1:0]),
        .sample_interval (sample_interval_reg),
        .out_valid       (acc_valid),
        .out_ready       (acc_ready),
        .out_item        (acc_item)
    );

    avm_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (acc_valid),
        .in_ready      (acc_ready),
        .in_item       (acc_item),
        .full_scale_mv (full_scale_reg),
        .out_valid     (scl_valid),
        .out_ready     (scl_ready),
        .out_item      (scl_item)
    );

    avm_digits u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_item   (scl_item),
        .out_valid (dig_valid),
        .out_ready (dig_ready),
        .out_item  (dig_item)
    );

    avm_disp u_disp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (dig_valid),
        .in_ready        (dig_ready),
        .in_item         (dig_item),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .segment_pattern (segment_pattern),
        .digit_enable    (digit_enable),
        .reading_mv      (reading_mv),
        .new_reading     (m_tuser)
    );

    // Pack the result
    assign m_tdata = {6'd0, reading_mv, digit_enable, segment_pattern};

    // Exactly one digit is enabled on every result
    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(~m_tdata[11:8]))
        else $error("digit enable is not one-cold");

    // The reading never exceeds the saturation limit
    a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:12] <= avm_pkg::MV_MAX))
        else $error("reading above saturation limit");

    // Input backpressure only comes from a stalled result
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the result side is free");

endmodule

// ----- verif/tb_adc_average_voltmeter_display.sv -----
`timescale 1ns / 1ps
// Testbench for the averaging voltmeter with its multiplexed display. It drives
// timer ticks and register writes and checks every result against its own model.
// Depends on avm_pkg and the adc_average_voltmeter_display top level.
module tb_adc_average_voltmeter_display;

    // Register indexes that the block ignores
    localparam logic [avm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [avm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int unsigned ADC_TOP = 1023;
    localparam logic [avm_pkg::SEG_W-1:0] SEG_ZERO = 8'hC0;
    localparam logic [avm_pkg::SEG_W-1:0] SEG_NINE = 8'h90;
    localparam int DIR_ROWS = 24;
    localparam int DIR_RECONFIG_ROW = 4;

    typedef struct packed {
        logic [avm_pkg::SEG_W-1:0] seg;
        logic [avm_pkg::DIG_W-1:0] en;
        logic [avm_pkg::MV_W-1:0]  mv;
        logic                      fresh;
    } reading_t;

    typedef struct packed {
        bit                        typed;
        logic [avm_pkg::ADC_W-1:0] adc;
        reading_t                  exp_r;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [avm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [avm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Voltmeter state as the block should hold it
    logic [avm_pkg::SI_W-1:0]  vm_interval;
    logic [avm_pkg::FS_W-1:0]  vm_full_scale;
    logic [7:0]                vm_ticks;
    logic [avm_pkg::SUM_W-1:0] vm_sum;
    logic [4:0]                vm_count;
    logic [avm_pkg::DIG_W-1:0] vm_digits [0:3];
    logic [avm_pkg::POS_W-1:0] vm_scan;
    logic [avm_pkg::MV_W-1:0]  vm_last_mv;
    logic [avm_pkg::SEG_W-1:0] seg_font [0:9] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                                   8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

    reading_t  reading_q [$];
    stim_row_t dir_rows [0:DIR_ROWS-1];
    int        mismatch_count = 0;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        adc_level = 512;

    adc_average_voltmeter_display u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Show the digit from the buffer as it stood, then take the sample
    task automatic meter_tick(input logic [avm_pkg::ADC_W-1:0] adc, output reading_t r);
        int unsigned avg;
        int unsigned mv;
        begin
            r.seg = seg_font[vm_digits[vm_scan]];
            r.en = ~(4'b0001 << vm_scan);
            r.fresh = 1'b0;
            vm_scan = vm_scan + 1'b1;
            vm_ticks = vm_ticks + 1'b1;
            if (vm_ticks >= vm_interval)
            begin
                vm_ticks = '0;
                vm_sum = vm_sum + adc;
                vm_count = vm_count + 1'b1;
                if (vm_count >= avm_pkg::SAMPLES)
                begin
                    avg = vm_sum / avm_pkg::SAMPLES;
                    mv = avg * vm_full_scale / ADC_TOP;
                    if (mv > avm_pkg::MV_MAX)
                        mv = avm_pkg::MV_MAX;
                    vm_sum = '0;
                    vm_count = '0;
                    vm_last_mv = mv[avm_pkg::MV_W-1:0];
                    vm_digits[0] = avm_pkg::DIG_W'((mv / 1000) % 10);
                    vm_digits[1] = avm_pkg::DIG_W'((mv / 100) % 10);
                    vm_digits[2] = avm_pkg::DIG_W'((mv / 10) % 10);
                    vm_digits[3] = avm_pkg::DIG_W'(mv % 10);
                    r.fresh = 1'b1;
                end
            end
            r.mv = vm_last_mv;
        end
    endtask

    // Slow-moving levels half the time, so averages land all over the scale
    function automatic logic [avm_pkg::ADC_W-1:0] pick_adc();
        int v;
        begin
            if ($urandom_range(0, 15) == 0)
                adc_level = $urandom_range(0, ADC_TOP);
            case ($urandom_range(0, 7))
                0: v = 0;
                1: v = ADC_TOP;
                2, 3: v = $urandom_range(0, ADC_TOP);
                default: v = adc_level + $urandom_range(0, 3);
            endcase
            if (v > ADC_TOP)
                v = ADC_TOP;
            return v[avm_pkg::ADC_W-1:0];
        end
    endfunction

    // Hold valid until the tick is taken, then record what it must produce
    task automatic send_tick(input logic [avm_pkg::ADC_W-1:0] adc, input bit typed,
                             input reading_t typed_r);
        int gap;
        reading_t r;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < src_idle_pct)
                gap++;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {6'b0, adc};
            do @(posedge clk); while (!s_tready);
            meter_tick(adc, r);
            reading_q.push_back(typed ? typed_r : r);
        end
    endtask

    task automatic wait_drained();
        begin
            s_tvalid <= 1'b0;
            while (reading_q.size() != 0)
                @(posedge clk);
        end
    endtask

    // Leave valid high; the caller drops it after the last write
    task automatic cfg_write(input logic [avm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [avm_pkg::CFG_DATA_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            do @(posedge clk); while (!cfg_ready);
            if (idx == avm_pkg::CFG_SAMPLE_INTERVAL)
                vm_interval = data[avm_pkg::SI_W-1:0];
            else if (idx == avm_pkg::CFG_FULL_SCALE)
                vm_full_scale = data;
        end
    endtask

    // Reprogram while idle, then stream random ticks
    task automatic run_phase(input logic [avm_pkg::CFG_DATA_W-1:0] si_data,
                             input logic [avm_pkg::CFG_DATA_W-1:0] fs, input int src,
                             input int snk, input int n, input bit pause_mid);
        begin
            wait_drained();
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      avm_pkg::CFG_DATA_W'($urandom));
            cfg_write(avm_pkg::CFG_SAMPLE_INTERVAL, si_data);
            cfg_write(avm_pkg::CFG_FULL_SCALE, fs);
            cfg_valid <= 1'b0;
            src_idle_pct = src;
            snk_stall_pct = snk;
            for (int i = 0; i < n; i++)
            begin
                if (pause_mid && i == n / 2)
                    wait_drained();
                send_tick(pick_adc(), 1'b0, '0);
            end
        end
    endtask

    // Compare each result transaction with the oldest expectation
    task automatic check_reading();
        reading_t want;
        reading_t got;
        begin
            got.seg = m_tdata[7:0];
            got.en = m_tdata[11:8];
            got.mv = m_tdata[25:12];
            got.fresh = m_tuser;
            if (reading_q.size() == 0)
            begin
                $error("unexpected result transaction: %h", got);
                mismatch_count++;
            end
            else
            begin
                want = reading_q.pop_front();
                if (got.seg !== want.seg)
                begin
                    $error("segment_pattern: expected %h, got %h", want.seg, got.seg);
                    mismatch_count++;
                end
                if (got.en !== want.en)
                begin
                    $error("digit_enable: expected %b, got %b", want.en, got.en);
                    mismatch_count++;
                end
                if (got.mv !== want.mv)
                begin
                    $error("reading_mv: expected %0d, got %0d", want.mv, got.mv);
                    mismatch_count++;
                end
                if (got.fresh !== want.fresh)
                begin
                    $error("new_reading: expected %b, got %b", want.fresh, got.fresh);
                    mismatch_count++;
                end
            end
        end
    endtask

    // Sample results, then decide readiness for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_reading();
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    initial
    begin
        vm_interval = avm_pkg::SAMPLE_INTERVAL_RESET;
        vm_full_scale = avm_pkg::FULL_SCALE_RESET;
        vm_ticks = '0;
        vm_sum = '0;
        vm_count = '0;
        vm_scan = '0;
        vm_last_mv = '0;
        for (int i = 0; i < 4; i++)
            vm_digits[i] = '0;

        // Reset state first, then sixteen full-scale samples with the
        // scale above 9999 so the reading saturates, then the nines scan out
        dir_rows = '{
            '{1'b1, 10'd0,    '{SEG_ZERO, 4'b1110, 14'd0, 1'b0}},
            '{1'b1, 10'd1023, '{SEG_ZERO, 4'b1101, 14'd0, 1'b0}},
            '{1'b1, 10'h2AA,  '{SEG_ZERO, 4'b1011, 14'd0, 1'b0}},
            '{1'b1, 10'h155,  '{SEG_ZERO, 4'b0111, 14'd0, 1'b0}},
            '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0},
            '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0},
            '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0},
            '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0},
            '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0}, '{1'b0, 10'd1023, '0},
            '{1'b1, 10'd1023, '{SEG_ZERO, 4'b0111, 14'd9999, 1'b1}},
            '{1'b1, 10'd0,    '{SEG_NINE, 4'b1110, 14'd9999, 1'b0}},
            '{1'b1, 10'd0,    '{SEG_NINE, 4'b1101, 14'd9999, 1'b0}},
            '{1'b1, 10'd0,    '{SEG_NINE, 4'b1011, 14'd9999, 1'b0}},
            '{1'b1, 10'd0,    '{SEG_NINE, 4'b0111, 14'd9999, 1'b0}}
        };

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            // An interval of zero samples every tick
            if (i == DIR_RECONFIG_ROW)
            begin
                wait_drained();
                cfg_write(avm_pkg::CFG_SAMPLE_INTERVAL, 14'd0);
                cfg_write(avm_pkg::CFG_FULL_SCALE, 14'h3FFF);
                cfg_valid <= 1'b0;
            end
            send_tick(dir_rows[i].adc, dir_rows[i].typed, dir_rows[i].exp_r);
        end

        run_phase(14'd1, 14'd5000, 0, 0, 140, 1'b0);
        run_phase(14'h3F00, 14'd9999, 51, 0, 130, 1'b1);
        run_phase(14'd2, 14'd1, 0, 51, 130, 1'b0);
        run_phase(14'd13, 14'h3FFF, 16, 16, 60, 1'b0);
        run_phase(14'd255, 14'd0, 16, 16, 40, 1'b0);
        run_phase(14'd1, avm_pkg::CFG_DATA_W'($urandom_range(1, 16383)), 0, 0, 130, 1'b0);
        run_phase(14'd0, avm_pkg::CFG_DATA_W'($urandom_range(1, 16383)), 16, 16, 140, 1'b1);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && reading_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
